// File: src/lfte_pkg.sv
// ----------------------------------------------------------------------------
// lfte_pkg
// Shared constants of the line folder: character codes, limits, reset values
// and configuration register indexes.
// ----------------------------------------------------------------------------
package lfte_pkg;

  localparam int LINE_MAX_DEF = 32;
  localparam int MAX_RESULTS  = 48;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_BAR   = 8'd124;

  localparam int FOLD_W_BITS = 6;
  localparam int TAB_S_BITS  = 5;
  localparam int COL_BITS    = 4;
  localparam int TAB_S_MAX   = 16;

  localparam logic [FOLD_W_BITS-1:0] FOLD_W_RST = 6'd10;
  localparam logic [TAB_S_BITS-1:0]  TAB_S_RST  = 5'd8;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOLD_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAB_STOP   = 2'd1;

endpackage

// File: src/line_folder_with_tab_expansion.sv
// ----------------------------------------------------------------------------
// line_folder_with_tab_expansion
// Expands tabs to the next tab stop and folds text lines at a set width,
// breaking after the last blank and marking each fold with '|' and newline.
// ----------------------------------------------------------------------------
//  channel  | signals                              | role
//  in       | in_valid, in_stall, in_char          | one text byte per request
//  out      | out_valid, out_stall, out_char,      | one emitted byte per request,
//           | out_last_of_run                      | last flag on final byte
//  cfg      | cfg_we, cfg_index, cfg_data          | fold_width (0), tab_stop (1)
//
//  a push writes one byte into the line buffer; emitted and moved buffer
//  bytes are read through its registered read port
//  a request pushes its bytes; a newline flush emits the line, and a fold
//  emits the line, moves any remainder to the front and adds '|' and newline
//  synchronous active-low reset clears fill count, tab column and handshakes
//  output stall holds the sequencer at its next emitted byte
// ----------------------------------------------------------------------------
module line_folder_with_tab_expansion #(
  parameter int LINE_MAX = lfte_pkg::LINE_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_char,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_char,
  output logic                               out_last_of_run,
  input  logic                               cfg_we,
  input  logic [lfte_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lfte_pkg::FOLD_W_BITS-1:0]   cfg_data
);
  import lfte_pkg::*;

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int AW = $clog2(LINE_MAX);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PUSH = 9'b000000010,
    S_RD   = 9'b000000100,
    S_EMIT = 9'b000001000,
    S_MRD  = 9'b000010000,
    S_MWR  = 9'b000100000,
    S_BAR  = 9'b001000000,
    S_NL   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [FOLD_W_BITS-1:0] fold_w_r;
  logic [TAB_S_BITS-1:0]  tab_s_r;
  logic [COL_BITS-1:0]    tab_col_r, tab_col_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic                   found_r, found_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          dst_r, dst_nxt;
  logic [CW-1:0]          len_r, len_nxt;
  logic [CW-1:0]          total_r, total_nxt;
  logic                   move_r, move_nxt;
  logic                   fold_r, fold_nxt;
  logic [7:0]             ch_r, ch_nxt;
  logic [TAB_S_BITS-1:0]  left_r, left_nxt;
  logic [RES_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [7:0]             pend_c_r, pend_c_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [7:0]             out_c_r, out_c_nxt;
  logic                   out_l_r, out_l_nxt;

  logic [7:0]             mem [LINE_MAX];
  logic [7:0]             rd_data_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [7:0]             mem_wdata;

  logic [CW-1:0]          eff_w;
  logic [TAB_S_BITS-1:0]  stop;
  logic [TAB_S_BITS-1:0]  col_eff, col_inc;
  logic                   out_free;
  logic                   emit_req, emit_done;
  logic [7:0]             emit_byte;
  logic                   fill_inc;
  logic [CW-1:0]          fill_new, k_new;
  logic                   found_new;

  always_comb begin
    if (fold_w_r == '0) begin
      eff_w = CW'(1);
    end else if (32'(fold_w_r) > LINE_MAX) begin
      eff_w = CW'(LINE_MAX);
    end else begin
      eff_w = CW'(fold_w_r);
    end
    if (tab_s_r == '0) begin
      stop = TAB_S_BITS'(1);
    end else if (32'(tab_s_r) > TAB_S_MAX) begin
      stop = TAB_S_BITS'(TAB_S_MAX);
    end else begin
      stop = tab_s_r;
    end
  end

  assign col_eff  = ({1'b0, tab_col_r} >= stop) ? '0 : {1'b0, tab_col_r};
  assign col_inc  = col_eff + TAB_S_BITS'(1);
  assign out_free = !out_v_r || !out_stall;
  assign fill_inc = fill_r < CW'(LINE_MAX);
  assign fill_new = fill_r + CW'(fill_inc);
  assign found_new = found_r || (ch_r == CH_SPACE);
  assign k_new    = (ch_r == CH_SPACE) ? fill_new : k_r;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_v_r;
  assign out_char        = out_c_r;
  assign out_last_of_run = out_l_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  // shared emitter: held byte is sent once next is known, or flagged last at done
  always_comb begin
    emit_done  = 1'b0;
    pend_v_nxt = pend_v_r;
    pend_c_nxt = pend_c_r;
    cnt_nxt    = cnt_r;
    out_v_nxt  = out_v_r && out_stall;
    out_c_nxt  = out_c_r;
    out_l_nxt  = out_l_r;
    if (emit_req) begin
      if (cnt_r == RES_CNT_W'(MAX_RESULTS)) begin
        emit_done = 1'b1;
      end else if (!pend_v_r || out_free) begin
        emit_done = 1'b1;
        if (pend_v_r) begin
          out_v_nxt = 1'b1;
          out_c_nxt = pend_c_r;
          out_l_nxt = 1'b0;
        end
        pend_v_nxt = 1'b1;
        pend_c_nxt = emit_byte;
        cnt_nxt    = cnt_r + RES_CNT_W'(1);
      end
    end else if (state_r == S_DONE && pend_v_r && out_free) begin
      out_v_nxt  = 1'b1;
      out_c_nxt  = pend_c_r;
      out_l_nxt  = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    tab_col_nxt = tab_col_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    found_nxt   = found_r;
    idx_nxt     = idx_r;
    dst_nxt     = dst_r;
    len_nxt     = len_r;
    total_nxt   = total_r;
    move_nxt    = move_r;
    fold_nxt    = fold_r;
    ch_nxt      = ch_r;
    left_nxt    = left_r;
    emit_req    = 1'b0;
    emit_byte   = rd_data_r;
    mem_we      = 1'b0;
    mem_waddr   = fill_r[AW-1:0];
    mem_wdata   = ch_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PUSH;
          if (in_char == CH_TAB) begin
            ch_nxt      = CH_SPACE;
            left_nxt    = stop - col_eff;
            tab_col_nxt = '0;
          end else if (in_char == CH_NL) begin
            ch_nxt      = CH_NL;
            left_nxt    = TAB_S_BITS'(1);
            tab_col_nxt = '0;
          end else begin
            ch_nxt      = in_char;
            left_nxt    = TAB_S_BITS'(1);
            tab_col_nxt = (col_inc >= stop) ? '0 : col_inc[COL_BITS-1:0];
          end
        end
      end
      S_PUSH: begin
        mem_we    = fill_inc;
        left_nxt  = left_r - TAB_S_BITS'(1);
        idx_nxt   = '0;
        total_nxt = fill_new;
        move_nxt  = 1'b0;
        k_nxt     = k_new;
        found_nxt = found_new;
        if (ch_r == CH_NL) begin
          len_nxt   = fill_new;
          fold_nxt  = 1'b0;
          fill_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = S_RD;
        end else if (fill_new < eff_w) begin
          fill_nxt  = fill_new;
          state_nxt = (left_r == TAB_S_BITS'(1)) ? S_DONE : S_PUSH;
        end else begin
          fold_nxt  = 1'b1;
          found_nxt = 1'b0;
          state_nxt = S_RD;
          if (!found_new || k_new == fill_new) begin
            len_nxt  = fill_new;
            fill_nxt = '0;
          end else begin
            len_nxt  = k_new;
            move_nxt = 1'b1;
            fill_nxt = fill_new - k_new;
          end
        end
      end
      S_RD: begin
        if (idx_r == len_r) begin
          dst_nxt = '0;
          if (move_r) begin
            state_nxt = S_MRD;
          end else if (fold_r) begin
            state_nxt = S_BAR;
          end else begin
            state_nxt = (left_r == '0) ? S_DONE : S_PUSH;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        emit_req = 1'b1;
        if (emit_done) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_RD;
        end
      end
      S_MRD: begin
        state_nxt = (idx_r == total_r) ? S_BAR : S_MWR;
      end
      S_MWR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r[AW-1:0];
        mem_wdata = rd_data_r;
        idx_nxt   = idx_r + CW'(1);
        dst_nxt   = dst_r + CW'(1);
        state_nxt = S_MRD;
      end
      S_BAR: begin
        emit_req  = 1'b1;
        emit_byte = CH_BAR;
        if (emit_done) begin
          state_nxt = S_NL;
        end
      end
      S_NL: begin
        emit_req  = 1'b1;
        emit_byte = CH_NL;
        if (emit_done) begin
          state_nxt = (left_r == '0) ? S_DONE : S_PUSH;
        end
      end
      S_DONE: begin
        if (!pend_v_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fold_w_r  <= FOLD_W_RST;
      tab_s_r   <= TAB_S_RST;
      tab_col_r <= '0;
      fill_r    <= '0;
      found_r   <= 1'b0;
      cnt_r     <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tab_col_r <= tab_col_nxt;
      fill_r    <= fill_nxt;
      found_r   <= found_nxt;
      cnt_r     <= (state_r == S_IDLE) ? '0 : cnt_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
      if (cfg_we && cfg_index == REG_FOLD_WIDTH) begin
        fold_w_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_TAB_STOP) begin
        tab_s_r <= cfg_data[TAB_S_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    idx_r    <= idx_nxt;
    dst_r    <= dst_nxt;
    len_r    <= len_nxt;
    total_r  <= total_nxt;
    move_r   <= move_nxt;
    fold_r   <= fold_nxt;
    ch_r     <= ch_nxt;
    left_r   <= left_nxt;
    pend_c_r <= pend_c_nxt;
    out_c_r  <= out_c_nxt;
    out_l_r  <= out_l_nxt;
  end

  a_held_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> cnt_r != '0)
    else $error("held byte without a counted result");

  a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("byte still held while ready for a new request");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(LINE_MAX))
    else $error("fill count beyond buffer depth");

  a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_PUSH)
    else $error("accepted request did not start a push");

  a_results_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count past its limit");

endmodule

// File: verif/tb_line_folder_with_tab_expansion.sv
// ----------------------------------------------------------------------------
// tb_line_folder_with_tab_expansion
// Self-checking bench for the line folder. A shadow copy of the fold width,
// tab stop, line buffer and tab column predicts every emitted byte and its
// last-of-run flag. Directed text covers byte extremes, tabs, blanks,
// newlines and clamped register values. Random word-like text then runs
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_folder_with_tab_expansion;
  import lfte_pkg::*;

  localparam int IDLE_PCT   = 23;
  localparam int TAIL_CYC   = 120;
  localparam int STUCK_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_flag;
  } folded_byte_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              in_char = 8'd0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [7:0]              out_char;
  logic                    out_last_of_run;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_FOLD_WIDTH;
  logic [FOLD_W_BITS-1:0]  cfg_data = '0;

  logic [7:0]              text_q[$];
  folded_byte_t            folded_exp_q[$];
  int unsigned             queued_cnt = 0;
  int unsigned             taken_cnt = 0;
  int unsigned             err_cnt = 0;
  int unsigned             stuck_cnt = 0;
  logic                    steady = 1'b0;

  // shadow of the block state
  logic [FOLD_W_BITS-1:0]  fold_w_shadow = FOLD_W_RST;
  logic [TAB_S_BITS-1:0]   tab_s_shadow = TAB_S_RST;
  logic [7:0]              line_shadow[LINE_MAX_DEF];
  int                      fill_shadow = 0;
  int                      col_shadow = 0;
  logic [7:0]              run_q[$];

  line_folder_with_tab_expansion i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char         (in_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void emit_line_front(int n);
    for (int i = 0; i < n; i++) begin
      if (run_q.size() < MAX_RESULTS) run_q.push_back(line_shadow[i]);
    end
  endfunction

  function automatic void emit_mark(logic [7:0] ch);
    if (run_q.size() < MAX_RESULTS) run_q.push_back(ch);
  endfunction

  function automatic void buffer_char(logic [7:0] ch);
    int w;
    int k;
    w = (fold_w_shadow == 0) ? 1 :
        (fold_w_shadow > LINE_MAX_DEF) ? LINE_MAX_DEF : int'(fold_w_shadow);
    k = 0;
    if (fill_shadow < LINE_MAX_DEF) begin
      line_shadow[fill_shadow] = ch;
      fill_shadow++;
    end
    if (ch == CH_NL) begin
      emit_line_front(fill_shadow);
      fill_shadow = 0;
      return;
    end
    if (fill_shadow < w) return;
    for (int i = fill_shadow; i > 0; i--) begin
      if (line_shadow[i-1] == CH_SPACE) begin
        k = i;
        break;
      end
    end
    if (k == 0 || k == fill_shadow) begin
      emit_line_front(fill_shadow);
      fill_shadow = 0;
    end else begin
      emit_line_front(k);
      for (int i = 0; i < fill_shadow - k; i++) line_shadow[i] = line_shadow[i+k];
      fill_shadow -= k;
    end
    emit_mark(CH_BAR);
    emit_mark(CH_NL);
  endfunction

  function automatic void predict_folded_bytes(logic [7:0] ch);
    int stop;
    folded_byte_t fb;
    stop = (tab_s_shadow == 0) ? 1 :
           (tab_s_shadow > TAB_S_MAX) ? TAB_S_MAX : int'(tab_s_shadow);
    run_q.delete();
    if (col_shadow >= stop) col_shadow = 0;
    if (ch == CH_TAB) begin
      repeat (stop - col_shadow) buffer_char(CH_SPACE);
      col_shadow = 0;
    end else if (ch == CH_NL) begin
      buffer_char(ch);
      col_shadow = 0;
    end else begin
      buffer_char(ch);
      col_shadow++;
      if (col_shadow >= stop) col_shadow = 0;
    end
    for (int i = 0; i < run_q.size(); i++) begin
      fb.ch = run_q[i];
      fb.last_flag = (i == run_q.size() - 1);
      folded_exp_q.push_back(fb);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_folded_bytes(in_char);
        taken_cnt++;
      end
      if (text_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_char  <= text_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // result monitor
  always @(posedge clk) begin
    folded_byte_t fb;
    if (rst_n && out_valid && !out_stall) begin
      if (folded_exp_q.size() == 0) begin
        $error("unexpected result: out_char %0d out_last_of_run %0b",
               out_char, out_last_of_run);
        err_cnt++;
      end else begin
        fb = folded_exp_q.pop_front();
        if (out_char !== fb.ch) begin
          $error("out_char: expected %0d, got %0d", fb.ch, out_char);
          err_cnt++;
        end
        if (out_last_of_run !== fb.last_flag) begin
          $error("out_last_of_run: expected %0b, got %0b", fb.last_flag, out_last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("line_folder_with_tab_expansion regression: fail");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [FOLD_W_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FOLD_WIDTH) fold_w_shadow = val;
    else tab_s_shadow = val[TAB_S_BITS-1:0];
  endtask

  task automatic queue_text(input logic [7:0] ch);
    text_q.push_back(ch);
    queued_cnt++;
  endtask

  task automatic wait_drained(input int tail);
    do @(negedge clk); while (taken_cnt != queued_cnt || folded_exp_q.size() != 0);
    repeat (tail) @(negedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(97, 122));
    if (r < 73) return CH_SPACE;
    if (r < 81) return CH_TAB;
    if (r < 88) return CH_NL;
    if (r < 92) return CH_BAR;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    static logic [7:0] word_txt[14] = '{8'd0, 8'hff, "a", CH_TAB, "w", "o", "r", "d",
                                        CH_SPACE, CH_BAR, CH_NL, "x", "y", "z"};
    static logic [FOLD_W_BITS-1:0] fw_set[8] = '{6'd32, 6'd1, 6'd2, 6'd7, 6'd15, 6'd20,
                                                 6'd5, 6'd0};
    static logic [TAB_S_BITS-1:0]  ts_set[8] = '{5'd16, 5'd1, 5'd3, 5'd4, 5'd16, 5'd8,
                                                 5'd2, 5'd0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed text under reset settings, ends mid-line
    foreach (word_txt[i]) queue_text(word_txt[i]);
    wait_drained(TAIL_CYC);

    // zero width and zero stop, column left beyond the new stop
    write_reg(REG_FOLD_WIDTH, 6'd0);
    write_reg(REG_TAB_STOP, 6'd0);
    queue_text(CH_TAB);
    queue_text("q");
    queue_text(CH_SPACE);
    queue_text(CH_NL);
    queue_text(CH_NL);
    wait_drained(TAIL_CYC);

    // saturated width and stop, fold landing on a blank
    write_reg(REG_FOLD_WIDTH, 6'd63);
    write_reg(REG_TAB_STOP, 6'd31);
    queue_text(CH_TAB);
    queue_text(CH_TAB);
    queue_text("a");
    queue_text(CH_TAB);
    queue_text(CH_NL);
    wait_drained(TAIL_CYC);

    fw_set[7] = 6'($urandom_range(63));
    ts_set[7] = 5'($urandom_range(31));
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_FOLD_WIDTH, fw_set[p]);
      write_reg(REG_TAB_STOP, 6'(ts_set[p]));
      steady = (p == 3);
      for (int n = 0; n < 50; n++) begin
        queue_text(text_byte());
        if (p == 5 && n == 25) wait_drained(0);
      end
      wait_drained(TAIL_CYC);
    end

    if (err_cnt == 0) begin
      $display("line_folder_with_tab_expansion regression: pass");
    end else begin
      $display("line_folder_with_tab_expansion regression: fail");
    end
    $finish;
  end

endmodule
